// ===== sv/wsd_pkg.sv =====
// wsd_pkg: shared types and codes for the websocket receive deframer
// no dependencies

package wsd_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int ERR_W    = 2;
  localparam int STATUS_W = 16;
  localparam int LEFT_W   = 7;

  localparam logic [BYTE_W-1:0] HDR_FIN       = 8'h80;
  localparam logic [BYTE_W-1:0] OP_TEXT       = 8'h01;
  localparam logic [BYTE_W-1:0] OP_CLOSE      = 8'h08;
  localparam logic [BYTE_W-1:0] MASK_BIT      = 8'h80;
  localparam logic [BYTE_W-1:0] LEN_BITS      = 8'h7f;
  localparam logic [BYTE_W-1:0] MAX_SMALL_LEN = 8'd125;
  localparam logic [BYTE_W-1:0] MIN_CLOSE_LEN = 8'd2;

  localparam logic [KIND_W-1:0] EV_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] EV_PAYLOAD   = 3'd1;
  localparam logic [KIND_W-1:0] EV_EMPTY     = 3'd2;
  localparam logic [KIND_W-1:0] EV_ERROR     = 3'd3;
  localparam logic [KIND_W-1:0] EV_SRV_CLOSE = 3'd4;
  localparam logic [KIND_W-1:0] EV_STATUS    = 3'd5;
  localparam logic [KIND_W-1:0] EV_FORCED    = 3'd6;

  localparam logic [ERR_W-1:0] ERR_LEN    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_MASKED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OPCODE = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TRUNC  = 2'd3;

  typedef enum logic [2:0] {
    ST_HDR0   = 3'd0,
    ST_HDR1   = 3'd1,
    ST_DATA   = 3'd2,
    ST_DROP   = 3'd3,
    ST_C_HDR0 = 3'd4,
    ST_C_HDR1 = 3'd5,
    ST_C_HIGH = 3'd6,
    ST_C_LOW  = 3'd7
  } step_t;

  typedef struct packed {
    logic [KIND_W-1:0]   event_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic                message_last;
    logic [ERR_W-1:0]    error_kind;
    logic [STATUS_W-1:0] close_status;
  } result_t;

endpackage

// ===== sv/wsd_parse.sv =====
// wsd_parse: frame parser state and combinational next-state/result logic
// depends on wsd_pkg

module wsd_parse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step_en,
  input  logic [wsd_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                         delivery_end,
  output wsd_pkg::result_t             res
);

  logic                          link_mode, link_mode_next;
  wsd_pkg::step_t                parse_step, parse_step_next;
  logic [wsd_pkg::LEFT_W-1:0]    bytes_left, bytes_left_next;
  logic                          delivery_start;
  logic [wsd_pkg::BYTE_W-1:0]    status_high, status_high_next;

  wsd_pkg::step_t                cur;
  logic [wsd_pkg::BYTE_W-1:0]    len;
  logic [wsd_pkg::LEFT_W-1:0]    left_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode      <= 1'b0;
      parse_step     <= wsd_pkg::ST_HDR0;
      bytes_left     <= '0;
      delivery_start <= 1'b1;
      status_high    <= '0;
    end else if (step_en) begin
      link_mode      <= link_mode_next;
      parse_step     <= parse_step_next;
      bytes_left     <= bytes_left_next;
      delivery_start <= delivery_end;
      status_high    <= status_high_next;
    end
  end

  always_comb begin
    cur = parse_step;
    if (delivery_start) begin
      cur = link_mode ? wsd_pkg::ST_C_HDR0 : wsd_pkg::ST_HDR0;
    end
    len      = rx_byte & wsd_pkg::LEN_BITS;
    left_dec = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;

    link_mode_next   = link_mode;
    parse_step_next  = cur;
    bytes_left_next  = bytes_left;
    status_high_next = status_high;
    res              = '0;

    case (cur)
      wsd_pkg::ST_HDR0: begin
        if (delivery_end) begin
          res.event_kind  = wsd_pkg::EV_ERROR;
          res.error_kind  = wsd_pkg::ERR_TRUNC;
          link_mode_next  = 1'b1;
          parse_step_next = wsd_pkg::ST_DROP;
        end else if (rx_byte == (wsd_pkg::HDR_FIN | wsd_pkg::OP_TEXT)) begin
          parse_step_next = wsd_pkg::ST_HDR1;
        end else if (rx_byte == (wsd_pkg::HDR_FIN | wsd_pkg::OP_CLOSE)) begin
          res.event_kind  = wsd_pkg::EV_SRV_CLOSE;
          link_mode_next  = 1'b1;
          parse_step_next = wsd_pkg::ST_DROP;
        end else begin
          res.event_kind  = wsd_pkg::EV_ERROR;
          res.error_kind  = wsd_pkg::ERR_OPCODE;
          link_mode_next  = 1'b1;
          parse_step_next = wsd_pkg::ST_DROP;
        end
      end
      wsd_pkg::ST_HDR1: begin
        if ((rx_byte & wsd_pkg::MASK_BIT) != '0) begin
          res.event_kind  = wsd_pkg::EV_ERROR;
          res.error_kind  = wsd_pkg::ERR_MASKED;
          link_mode_next  = 1'b1;
          parse_step_next = wsd_pkg::ST_DROP;
        end else if (len > wsd_pkg::MAX_SMALL_LEN) begin
          res.event_kind  = wsd_pkg::EV_ERROR;
          res.error_kind  = wsd_pkg::ERR_LEN;
          link_mode_next  = 1'b1;
          parse_step_next = wsd_pkg::ST_DROP;
        end else if (len == '0) begin
          res.event_kind  = wsd_pkg::EV_EMPTY;
          parse_step_next = wsd_pkg::ST_HDR0;
        end else begin
          bytes_left_next = len[wsd_pkg::LEFT_W-1:0];
          parse_step_next = wsd_pkg::ST_DATA;
        end
      end
      wsd_pkg::ST_DATA: begin
        res.event_kind   = wsd_pkg::EV_PAYLOAD;
        res.payload_byte = rx_byte;
        bytes_left_next  = left_dec;
        if (left_dec == '0 || delivery_end) begin
          res.message_last = 1'b1;
          bytes_left_next  = '0;
          parse_step_next  = wsd_pkg::ST_HDR0;
        end
      end
      wsd_pkg::ST_C_HDR0: begin
        if (rx_byte == (wsd_pkg::HDR_FIN | wsd_pkg::OP_CLOSE) && !delivery_end) begin
          parse_step_next = wsd_pkg::ST_C_HDR1;
        end else begin
          res.event_kind  = wsd_pkg::EV_FORCED;
          parse_step_next = wsd_pkg::ST_DROP;
        end
      end
      wsd_pkg::ST_C_HDR1: begin
        if ((rx_byte & wsd_pkg::MASK_BIT) == '0 && rx_byte >= wsd_pkg::MIN_CLOSE_LEN &&
            rx_byte <= wsd_pkg::MAX_SMALL_LEN && !delivery_end) begin
          parse_step_next = wsd_pkg::ST_C_HIGH;
        end else begin
          res.event_kind  = wsd_pkg::EV_FORCED;
          parse_step_next = wsd_pkg::ST_DROP;
        end
      end
      wsd_pkg::ST_C_HIGH: begin
        status_high_next = rx_byte;
        if (delivery_end) begin
          res.event_kind  = wsd_pkg::EV_FORCED;
          parse_step_next = wsd_pkg::ST_DROP;
        end else begin
          parse_step_next = wsd_pkg::ST_C_LOW;
        end
      end
      wsd_pkg::ST_C_LOW: begin
        res.event_kind   = wsd_pkg::EV_STATUS;
        res.close_status = {status_high, rx_byte};
        parse_step_next  = wsd_pkg::ST_DROP;
      end
      default: begin
        parse_step_next = wsd_pkg::ST_DROP;
      end
    endcase
  end

endmodule

// ===== sv/wsd_out_reg.sv =====
// wsd_out_reg: result register with valid/ready toward the consumer
// depends on wsd_pkg

module wsd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wsd_pkg::result_t  res_in,
  output logic              out_valid,
  input  logic              out_ready,
  output wsd_pkg::result_t  res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== sv/websocket_rx_frame_deframer.sv =====
// websocket_rx_frame_deframer: top level, input word register, parser and result register
// depends on wsd_pkg, wsd_parse, wsd_out_reg
//
// Takes one server byte per word and returns exactly one result word per byte
// (event_kind 0 when the byte produces nothing). Sustained rate is one byte per
// clock while the consumer takes results; the byte sits in the input register
// and the combinational parse step loads the result register when the result
// register is empty or being read.
// Both sides use valid/ready; the input register takes a new byte while a
// finished result still waits for the consumer.

module websocket_rx_frame_deframer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wsd_pkg::BYTE_W-1:0]     rx_byte,
  input  logic                           delivery_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wsd_pkg::KIND_W-1:0]     event_kind,
  output logic [wsd_pkg::BYTE_W-1:0]     payload_byte,
  output logic                           message_last,
  output logic [wsd_pkg::ERR_W-1:0]      error_kind,
  output logic [wsd_pkg::STATUS_W-1:0]   close_status
);

  logic                        s1_valid;
  logic [wsd_pkg::BYTE_W-1:0]  s1_byte;
  logic                        s1_end;
  logic                        s1_go;
  wsd_pkg::result_t            res;
  wsd_pkg::result_t            res_q;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
      s1_end  <= delivery_end;
    end
  end

  wsd_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .step_en      (s1_go),
    .rx_byte      (s1_byte),
    .delivery_end (s1_end),
    .res          (res)
  );

  wsd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go),
    .res_in    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign event_kind   = res_q.event_kind;
  assign payload_byte = res_q.payload_byte;
  assign message_last = res_q.message_last;
  assign error_kind   = res_q.error_kind;
  assign close_status = res_q.close_status;

endmodule

// ===== sv/wsd_checker.sv =====
// wsd_checker: port-level assertions for the deframer, bound to the top level
// depends on wsd_pkg, websocket_rx_frame_deframer

module wsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wsd_pkg::KIND_W-1:0]     event_kind,
  input logic [wsd_pkg::BYTE_W-1:0]     payload_byte,
  input logic                           message_last,
  input logic [wsd_pkg::ERR_W-1:0]      error_kind,
  input logic [wsd_pkg::STATUS_W-1:0]   close_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(payload_byte)
      && $stable(close_status))
    else $error("result word changed while stalled");

  a_payload_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != wsd_pkg::EV_PAYLOAD |-> payload_byte == '0 && !message_last)
    else $error("payload fields set outside a payload word");

  a_err_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != wsd_pkg::EV_ERROR |-> error_kind == '0)
    else $error("error kind set outside an error word");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != wsd_pkg::EV_STATUS |-> close_status == '0)
    else $error("close status set outside a status word");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind <= wsd_pkg::EV_FORCED)
    else $error("event kind out of range");

endmodule

bind websocket_rx_frame_deframer wsd_checker u_wsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_kind   (event_kind),
  .payload_byte (payload_byte),
  .message_last (message_last),
  .error_kind   (error_kind),
  .close_status (close_status)
);
